// ===== design/cfbb_pkg.sv =====
// Package for the clipped RGB565 rectangle blit core: field widths, codes,
// register map, reset values and the shared structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfbb_pkg;

   // Fixed field widths
   localparam int COORD_BITS_DEFAULT = 13;
   localparam int SIZE_BITS          = 13;
   localparam int STRIDE_BITS        = 16;
   localparam int PIXEL_BITS         = 16;
   localparam int OFFSET_BITS        = 28;
   localparam int DATA_BITS          = 32;
   localparam int RSP_DATA_BITS      = 64;   // offset + data, padded to bytes
   localparam int RSP_USER_BITS      = 2;    // write_enable, write_wide

   // Configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_LINE_STRIDE   = 2'd2,
      REG_WIDE_PIXELS   = 2'd3
   } csr_reg_type;

   // Reset values of the registers
   localparam logic [SIZE_BITS-1:0]   WIDTH_RESET  = SIZE_BITS'(240);
   localparam logic [SIZE_BITS-1:0]   HEIGHT_RESET = SIZE_BITS'(240);
   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(480);

   // Item kinds on the request channel (tuser)
   typedef enum logic {
      OP_START = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   // RGB565 channel masks
   localparam logic [4:0] RB_MASK = 5'h1f;
   localparam logic [5:0] G_MASK  = 6'h3f;

   typedef struct packed {
      logic [SIZE_BITS-1:0]   screen_width;
      logic [SIZE_BITS-1:0]   screen_height;
      logic [STRIDE_BITS-1:0] line_stride;
      logic                   wide_pixels;
   } cfg_type;

   typedef struct packed {
      logic                   write_enable;
      logic [OFFSET_BITS-1:0] write_offset;
      logic [DATA_BITS-1:0]   write_data;
      logic                   write_wide;
      logic                   rect_done;
   } pix_result_type;

   // RGB565 to XRGB8888, channels shifted up, no bit replication
   function automatic logic [DATA_BITS-1:0] expand_color(input logic [PIXEL_BITS-1:0] c);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      r = c[15:11] & RB_MASK;
      g = c[10:5] & G_MASK;
      b = c[4:0] & RB_MASK;
      return {8'h00, r, 3'b000, g, 2'b00, b, 3'b000};
   endfunction

endpackage

`default_nettype wire

// ===== design/cfbb_pixel_map.sv =====
// Per-pixel clip, framebuffer offset and color format for the blit core.
// Depends on cfbb_pkg (cfg_type, pix_result_type, expand_color).
`timescale 1ns / 1ps
`default_nettype none

module cfbb_pixel_map
   import cfbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire cfg_type                       cfg,
   input  wire logic signed [COORD_BITS-1:0]  cur_x,
   input  wire logic signed [COORD_BITS-1:0]  cur_y,
   input  wire logic signed [COORD_BITS-1:0]  end_x,
   input  wire logic signed [COORD_BITS-1:0]  last_y,
   input  wire logic [PIXEL_BITS-1:0]         color,
   output pix_result_type                     result
);

   localparam int CMP_W  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int PROD_W = COORD_BITS + STRIDE_BITS;
   localparam int SUM_W  = (PROD_W > OFFSET_BITS) ? PROD_W : OFFSET_BITS;

   logic [CMP_W-1:0] x_cmp;
   logic [CMP_W-1:0] y_cmp;
   logic             on_screen;
   logic [SUM_W-1:0] row_ofs;
   logic [SUM_W-1:0] col_ofs;
   logic [SUM_W-1:0] sum_ofs;

   // clip against 0..width-1 by 0..height-1
   assign x_cmp     = CMP_W'($unsigned(cur_x));
   assign y_cmp     = CMP_W'($unsigned(cur_y));
   assign on_screen = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                      (x_cmp < CMP_W'(cfg.screen_width)) &&
                      (y_cmp < CMP_W'(cfg.screen_height));

   // y*stride + x*bpp, low bits only
   assign row_ofs = SUM_W'($unsigned(cur_y)) * SUM_W'(cfg.line_stride);
   assign col_ofs = cfg.wide_pixels ? (SUM_W'($unsigned(cur_x)) << 2)
                                    : (SUM_W'($unsigned(cur_x)) << 1);
   assign sum_ofs = row_ofs + col_ofs;

   always_comb begin
      result.write_enable = on_screen;
      result.write_offset = on_screen ? sum_ofs[OFFSET_BITS-1:0] : '0;
      if (!on_screen) begin
         result.write_data = '0;
      end else if (cfg.wide_pixels) begin
         result.write_data = expand_color(color);
      end else begin
         result.write_data = DATA_BITS'(color);
      end
      result.write_wide = cfg.wide_pixels;
      result.rect_done  = (cur_x == end_x) && (cur_y == last_y);
   end

endmodule

`default_nettype wire

// ===== design/clipped_rgb565_framebuffer_blit_core.sv =====
// Clipped RGB565 rectangle blit core: top level with CSRs, cursor and
// result register. Depends on cfbb_pkg and cfbb_pixel_map.
//
// Usage:
//  - req channel: tuser is the item kind (start rectangle or pixel); a start
//    item carries the inclusive signed corners, a pixel item the RGB565 color.
//  - Pixels follow a start item in raster order, x fastest. Each pixel of an
//    active rectangle gives one rsp item: write enable (on screen or not),
//    byte offset y*stride + x*bpp, data (RGB565 or XRGB8888), wide flag, and
//    tlast on the last pixel. Start items and pixels with no rectangle give
//    no rsp item. An empty rectangle leaves no rectangle active.
//  - rsp_tvalid rises in the cycle after a pixel is accepted. Throughput:
//    one item per cycle unless stalled; clip, offset multiply-add and color
//    format sit between the cursor registers and the single rsp register.
//  - Stall: while rsp_tvalid is high and rsp_tready low, the result holds and
//    req_tready drops; req_tready follows rsp_tready the same cycle.
//  - Reset clears the rsp valid flag, drops any rectangle and reloads the
//    CSRs (width 240, height 240, stride 480, 16-bit mode).
//  - CSRs: 0 width, 1 height, 2 stride, 3 wide mode at byte address 4*i;
//    write them only while the core is idle.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rgb565_framebuffer_blit_core
   import cfbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + PIXEL_BITS + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request: tuser = operation
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // tdata: rect_left, rect_top, rect_right, rect_bottom, pixel_color, zero pad
   input  wire logic [REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic                       req_tuser,   // operation
   // result
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_DATA_BITS-1:0]        rsp_tdata,   // write_offset, write_data, zero pad
   output logic [RSP_USER_BITS-1:0]        rsp_tuser,   // write_enable, write_wide
   output logic                            rsp_tlast,   // rect_done
   // configuration
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                            csr_pready
);

   // ---------------- configuration registers ----------------
   cfg_type     cfg_ff, cfg_in;
   csr_reg_type csr_sel;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[SIZE_BITS-1:0];
            REG_LINE_STRIDE:   cfg_in.line_stride   = csr_pwdata[STRIDE_BITS-1:0];
            REG_WIDE_PIXELS:   cfg_in.wide_pixels   = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
         cfg_ff.line_stride   <= STRIDE_RESET;
         cfg_ff.wide_pixels   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_sel)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_height);
         REG_LINE_STRIDE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.line_stride);
         REG_WIDE_PIXELS:   csr_prdata = CSR_DATA_BITS'(cfg_ff.wide_pixels);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- request unpack ----------------
   logic signed [COORD_BITS-1:0] rect_left;
   logic signed [COORD_BITS-1:0] rect_top;
   logic signed [COORD_BITS-1:0] rect_right;
   logic signed [COORD_BITS-1:0] rect_bottom;
   logic [PIXEL_BITS-1:0]        pixel_color;

   assign rect_left   = req_tdata[COORD_BITS-1:0];
   assign rect_top    = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign rect_right  = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign rect_bottom = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign pixel_color = req_tdata[4*COORD_BITS+PIXEL_BITS-1:4*COORD_BITS];

   // ---------------- cursor state ----------------
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in;
   logic signed [COORD_BITS-1:0] last_y_ff, last_y_in;
   logic                         active_ff, active_in;

   pix_result_type pix;
   logic           req_acc;
   logic           pix_fire;

   cfbb_pixel_map #(
      .COORD_BITS (COORD_BITS)
   ) u_map (
      .cfg    (cfg_ff),
      .cur_x  (cur_x_ff),
      .cur_y  (cur_y_ff),
      .end_x  (end_x_ff),
      .last_y (last_y_ff),
      .color  (pixel_color),
      .result (pix)
   );

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign pix_fire   = req_acc && (op_type'(req_tuser) == OP_PIXEL) && active_ff;

   // next cursor: load on start, step on each pixel
   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      start_x_in = start_x_ff;
      end_x_in   = end_x_ff;
      last_y_in  = last_y_ff;
      active_in  = active_ff;
      if (req_acc && (op_type'(req_tuser) == OP_START)) begin
         cur_x_in   = rect_left;
         cur_y_in   = rect_top;
         start_x_in = rect_left;
         end_x_in   = rect_right;
         last_y_in  = rect_bottom;
         active_in  = (rect_right >= rect_left) && (rect_bottom >= rect_top);
      end else if (pix_fire) begin
         if (pix.rect_done) begin
            active_in = 1'b0;
         end else if (cur_x_ff == end_x_ff) begin
            cur_x_in = start_x_ff;
            cur_y_in = cur_y_ff + COORD_BITS'(1);
         end else begin
            cur_x_in = cur_x_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         start_x_ff <= '0;
         end_x_ff   <= '0;
         last_y_ff  <= '0;
         active_ff  <= 1'b0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         start_x_ff <= start_x_in;
         end_x_ff   <= end_x_in;
         last_y_ff  <= last_y_in;
         active_ff  <= active_in;
      end
   end

   // ---------------- result register ----------------
   logic           rsp_valid_ff, rsp_valid_in;
   pix_result_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pix_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         rsp_ff <= pix;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_ff.write_data, rsp_ff.write_offset});
   assign rsp_tuser  = {rsp_ff.write_wide, rsp_ff.write_enable};
   assign rsp_tlast  = rsp_ff.rect_done;

endmodule

`default_nettype wire

// ===== design/cfbb_checker.sv =====
// Port-level checks for the blit core, bound to the top level.
// Depends on cfbb_pkg and clipped_rgb565_framebuffer_blit_core.
`timescale 1ns / 1ps
`default_nettype none

module cfbb_checker
   import cfbb_pkg::*;
#(
   parameter int REQ_DATA_BITS = ((4 * COORD_BITS_DEFAULT + PIXEL_BITS + 7) / 8) * 8
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input wire logic                     req_tuser,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [RSP_USER_BITS-1:0] rsp_tuser,
   input wire logic                     rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // off-screen pixels carry zero offset and data
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("clipped pixel with nonzero offset or data");

   // a start item never produces a result
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (op_type'(req_tuser) == OP_START) |=> !rsp_tvalid)
      else $error("result after start item");

   // an empty result register never blocks the request side
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

endmodule

bind clipped_rgb565_framebuffer_blit_core cfbb_checker #(
   .REQ_DATA_BITS (REQ_DATA_BITS)
) u_cfbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
